/* hw/rtl/ssc_pkg.sv */
// Shared constants and types for the substring search and count block.
package ssc_pkg;

	// Needle capacity in bytes and the longest haystack that takes part in matching
	localparam int MAX_NEEDLE = 8;
	localparam int MAX_TEXT   = 65536;

	// Field widths
	localparam int BYTE_W   = 8;
	localparam int NEEDLE_W = 64;
	localparam int LEN_W    = 4;
	localparam int POS_W    = 16;
	localparam int CNT_W    = 16;
	localparam int GAP_W    = 4;

	// Byte index counter holds MAX_TEXT itself once the haystack runs past it
	localparam int IDX_W  = $clog2(MAX_TEXT + 1);
	localparam int NIDX_W = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;

	localparam logic [GAP_W-1:0] GAP_SAT   = {GAP_W{1'b1}};
	localparam logic [CNT_W-1:0] COUNT_SAT = {CNT_W{1'b1}};

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NEEDLE_BYTES  = 1'b0,
		REG_NEEDLE_LENGTH = 1'b1
	} cfg_reg_t;

	// Byte in stage 1, handed to the tally stage
	typedef struct packed {
		logic             valid;
		logic             last;
		logic             live;   // index below MAX_TEXT, byte takes part in matching
		logic [IDX_W-1:0] idx;    // index of this byte in the haystack
	} ssc_s1_t;

endpackage

/* hw/rtl/ssc_in_if.sv */
// Haystack byte channel: valid/ready handshake with the text byte and end mark.
interface ssc_in_if;
	import ssc_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_byte;
	logic              last_byte;

	modport source (output valid, output text_byte, output last_byte, input ready);
	modport sink   (input valid, input text_byte, input last_byte, output ready);

endinterface

/* hw/rtl/ssc_out_if.sv */
// Search result channel: valid/ready handshake with one result item per haystack.
interface ssc_out_if;
	import ssc_pkg::*;

	logic             valid;
	logic             ready;
	logic             found;
	logic [POS_W-1:0] first_position;
	logic [POS_W-1:0] last_position;
	logic [CNT_W-1:0] match_count;
	logic             overflow;

	modport source (output valid, output found, output first_position,
		output last_position, output match_count, output overflow, input ready);
	modport sink   (input valid, input found, input first_position,
		input last_position, input match_count, input overflow, output ready);

endinterface

/* hw/rtl/substring_search_count.sv */
// Top level of the streaming substring search and count block.
// One haystack byte is taken per clock cycle unless the input stalls, with no gaps
// between bytes or between haystacks; the row of eight window cells shifts and compares
// every searched byte in the cycle it is accepted, and the tally stage folds the hits in
// the next cycle. A haystack's result item is loaded when its last byte leaves stage 1 and
// waits in an output register; the input only stalls when a second result is ready while
// the first has not been taken. The needle and its length are written through the plain
// configuration port while the block is idle; a length of zero or above eight never
// matches. Bytes beyond the first 65536 of a haystack are not searched and set overflow,
// as does a saturated match count. Positions are start indexes counted from zero.
module substring_search_count (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [ssc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ssc_pkg::NEEDLE_W-1:0]  cfg_data,
	ssc_in_if.sink                        text_in,
	ssc_out_if.source                     result_out
);
	import ssc_pkg::*;

	logic [NEEDLE_W-1:0] needle_q;
	logic [LEN_W-1:0]    len_q;
	logic [IDX_W-1:0]    idx_q;
	ssc_s1_t             s1_q;

	logic accept;
	logic live;
	logic go;

	logic [BYTE_W-1:0]     cell_in   [MAX_NEEDLE];
	logic [BYTE_W-1:0]     cell_out  [MAX_NEEDLE];
	logic [BYTE_W-1:0]     cell_want [MAX_NEEDLE];
	logic [MAX_NEEDLE-1:0] hits;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_q <= '0;
			len_q    <= '0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_NEEDLE_BYTES:  needle_q <= cfg_data;
				REG_NEEDLE_LENGTH: len_q    <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign text_in.ready = !s1_q.valid || go;
	assign accept        = text_in.valid && text_in.ready;
	assign live          = (idx_q < IDX_W'(MAX_TEXT));

	// Byte index and stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			s1_q  <= '0;
		end else begin
			if (accept) begin
				s1_q.valid <= 1'b1;
				s1_q.last  <= text_in.last_byte;
				s1_q.live  <= live;
				s1_q.idx   <= idx_q;
				if (text_in.last_byte) begin
					idx_q <= '0;
				end else if (live) begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end else if (go) begin
				s1_q.valid <= 1'b0;
			end
		end
	end

	// Cell inputs: newest byte enters cell 0; cell j checks needle byte len-1-j
	always_comb begin
		logic [LEN_W-1:0]  k;
		logic [NIDX_W-1:0] kk;
		for (int j = 0; j < MAX_NEEDLE; j++) begin
			k  = len_q - LEN_W'(1) - LEN_W'(j);
			kk = k[NIDX_W-1:0];
			cell_want[j] = needle_q[BYTE_W*kk +: BYTE_W];
			cell_in[j]   = (j == 0) ? text_in.text_byte : cell_out[(j == 0) ? 0 : j - 1];
		end
	end

	// Window row
	for (genvar j = 0; j < MAX_NEEDLE; j++) begin : g_cell
		ssc_cell u_cell (
			.clk      (clk),
			.shift_en (accept && live),
			.din      (cell_in[j]),
			.want     (cell_want[j]),
			.dout     (cell_out[j]),
			.hit      (hits[j])
		);
	end

	ssc_tally u_tally (
		.clk           (clk),
		.arst_n        (arst_n),
		.s1            (s1_q),
		.hits          (hits),
		.needle_length (len_q),
		.go            (go),
		.result_out    (result_out)
	);

	// A fresh result only follows a last byte in stage 1
	a_result_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_out.valid) |-> $past(s1_q.valid && s1_q.last))
		else $error("result appeared without a last byte");

	// No match means zero positions and zero count
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && !result_out.found) |->
		(result_out.first_position == '0 && result_out.last_position == '0 &&
		 result_out.match_count == '0))
		else $error("result without match carries nonzero fields");

	// Byte index never passes the text limit
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_W'(MAX_TEXT))
		else $error("byte index past text limit");

	// Input only stalls behind a pending result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!text_in.ready |-> (s1_q.valid && s1_q.last && result_out.valid))
		else $error("input stalled without a pending result");

endmodule

/* hw/rtl/ssc_cell.sv */
// One window cell: holds a haystack byte, passes it on, and registers its needle compare.
module ssc_cell (
	input  logic                       clk,
	input  logic                       shift_en,
	input  logic [ssc_pkg::BYTE_W-1:0] din,
	input  logic [ssc_pkg::BYTE_W-1:0] want,
	output logic [ssc_pkg::BYTE_W-1:0] dout,
	output logic                       hit
);
	import ssc_pkg::*;

	logic [BYTE_W-1:0] byte_q;
	logic              hit_q;

	// Take the incoming byte (the neighbor's, or the haystack byte in cell 0) and compare it with this cell's needle byte
	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= din;
			hit_q  <= (din == want);
		end
	end

	assign dout = byte_q;
	assign hit  = hit_q;

endmodule

/* hw/rtl/ssc_tally.sv */
// Match tally stage: combines cell hits, tracks first/last/count, holds the result item.
module ssc_tally (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ssc_pkg::ssc_s1_t             s1,
	input  logic [ssc_pkg::MAX_NEEDLE-1:0] hits,
	input  logic [ssc_pkg::LEN_W-1:0]    needle_length,
	output logic                         go,
	ssc_out_if.source                    result_out
);
	import ssc_pkg::*;

	logic             out_v_q;
	logic             found_q;
	logic [POS_W-1:0] first_out_q;
	logic [POS_W-1:0] last_out_q;
	logic [CNT_W-1:0] count_out_q;
	logic             ovf_out_q;

	logic [GAP_W-1:0] gap_q;
	logic             seen_q;
	logic [POS_W-1:0] first_q;
	logic [POS_W-1:0] latest_q;
	logic [CNT_W-1:0] count_q;
	logic             too_long_q;

	logic [GAP_W-1:0] gap_d;
	logic             seen_d;
	logic [POS_W-1:0] first_d;
	logic [POS_W-1:0] latest_d;
	logic [CNT_W-1:0] count_d;
	logic             too_long_d;

	logic [MAX_NEEDLE-1:0] use_mask;
	logic                  len_ok;
	logic [IDX_W-1:0]      idx_p1;
	logic [IDX_W-1:0]      start;
	logic                  match;

	// Stage holds only when a result must be loaded and the output is still full
	assign go = !(s1.valid && s1.last && out_v_q && !result_out.ready);

	// Window match over the cells that the needle length covers
	always_comb begin
		for (int j = 0; j < MAX_NEEDLE; j++) begin
			use_mask[j] = (LEN_W'(j) < needle_length);
		end
		len_ok = (needle_length != '0) && (needle_length <= LEN_W'(MAX_NEEDLE));
		idx_p1 = s1.idx + IDX_W'(1);
		start  = idx_p1 - IDX_W'(needle_length);
		match  = len_ok && (idx_p1 >= IDX_W'(needle_length)) && (&(hits | ~use_mask));
	end

	// Next statistics after this byte
	always_comb begin
		gap_d      = gap_q;
		seen_d     = seen_q;
		first_d    = first_q;
		latest_d   = latest_q;
		count_d    = count_q;
		too_long_d = too_long_q;
		if (s1.valid && !s1.live) begin
			too_long_d = 1'b1;
		end else if (s1.valid) begin
			if (gap_q != GAP_SAT) begin
				gap_d = gap_q + GAP_W'(1);
			end
			if (match) begin
				if (!seen_q) begin
					first_d = POS_W'(start);
				end
				seen_d   = 1'b1;
				latest_d = POS_W'(start);
				// Greedy non-overlapping count: only once the previous counted match is past
				if (gap_d >= GAP_W'(needle_length)) begin
					if (count_q != COUNT_SAT) begin
						count_d = count_q + CNT_W'(1);
					end else begin
						too_long_d = 1'b1;
					end
					gap_d = '0;
				end
			end
		end
	end

	// Statistics registers, cleared after the last byte of a haystack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q      <= GAP_SAT;
			seen_q     <= 1'b0;
			first_q    <= '0;
			latest_q   <= '0;
			count_q    <= '0;
			too_long_q <= 1'b0;
		end else if (s1.valid && go) begin
			if (s1.last) begin
				gap_q      <= GAP_SAT;
				seen_q     <= 1'b0;
				first_q    <= '0;
				latest_q   <= '0;
				count_q    <= '0;
				too_long_q <= 1'b0;
			end else begin
				gap_q      <= gap_d;
				seen_q     <= seen_d;
				first_q    <= first_d;
				latest_q   <= latest_d;
				count_q    <= count_d;
				too_long_q <= too_long_d;
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1.valid && s1.last && go) begin
			out_v_q <= 1'b1;
		end else if (result_out.ready) begin
			out_v_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (s1.valid && s1.last && go) begin
			found_q     <= seen_d;
			first_out_q <= first_d;
			last_out_q  <= latest_d;
			count_out_q <= count_d;
			ovf_out_q   <= too_long_d;
		end
	end

	assign result_out.valid          = out_v_q;
	assign result_out.found          = found_q;
	assign result_out.first_position = first_out_q;
	assign result_out.last_position  = last_out_q;
	assign result_out.match_count    = count_out_q;
	assign result_out.overflow       = ovf_out_q;

endmodule
